/* hw/rtl/cpg_pkg.sv */
// Package for the circle point generator: request codes, octant constants
// and the step record passed from the front end to the point emitter.
// No dependencies.
package cpg_pkg;

    // Request codes on the input channel.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Octant index of the eighth point of a step.
    localparam logic [2:0] OCT_LAST = 3'd7;

    // Depth of the queue between front end and point emitter.
    localparam int unsigned Q_DEPTH = 2;

    // One step worth of geometry, ready to be mirrored eight ways.
    typedef struct packed {
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic signed [11:0] offset_x;
        logic signed [11:0] offset_y;
        logic               done;
    } t_step_rec;

endpackage

/* hw/rtl/cpg_front.sv */
// Front end of the circle point generator: accepts requests, runs the
// midpoint decision update and pushes one step record per productive item.
// Depends on cpg_pkg.
module cpg_front import cpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic signed [10:0] i_center_x,
    input  logic signed [10:0] i_center_y,
    input  logic        [9:0]  i_radius,
    input  logic               i_q_full,
    output logic               o_push,
    output t_step_rec          o_rec
);

    logic signed [11:0] r_off_x, n_off_x;
    logic signed [11:0] r_off_y, n_off_y;
    logic signed [15:0] r_dec,   n_dec;
    logic signed [10:0] r_org_x, n_org_x;
    logic signed [10:0] r_org_y, n_org_y;
    logic               r_active, n_active;

    logic               accept;
    logic               dec_pos;
    logic signed [11:0] step_x;
    logic signed [11:0] step_y;
    logic        [15:0] step_x16;
    logic        [15:0] diff16;
    logic        [15:0] step_dec;
    logic               step_done;
    logic               done;

    // An item is taken whenever the queue has room.
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // One midpoint step from the stored state.
    always_comb begin
        dec_pos  = (r_dec > 16'sd0);
        step_x   = r_off_x + 12'sd1;
        step_y   = dec_pos ? (r_off_y - 12'sd1) : r_off_y;
        step_x16 = {{4{step_x[11]}}, step_x};
        diff16   = step_x16 - {{4{step_y[11]}}, step_y};
        if (dec_pos) begin
            step_dec = r_dec + (diff16 << 2) + 16'd10;
        end else begin
            step_dec = r_dec + (step_x16 << 2) + 16'd6;
        end
        step_done = (step_y < step_x);
    end

    // Next state: a start reloads everything, a step advances while active.
    always_comb begin
        n_off_x  = r_off_x;
        n_off_y  = r_off_y;
        n_dec    = r_dec;
        n_org_x  = r_org_x;
        n_org_y  = r_org_y;
        n_active = r_active;
        done     = 1'b0;
        o_push   = 1'b0;
        if (accept) begin
            if (i_req_type == REQ_START) begin
                n_org_x  = i_center_x;
                n_org_y  = i_center_y;
                n_off_x  = 12'sd0;
                n_off_y  = $signed({2'b00, i_radius});
                n_dec    = $signed(16'd3 - {5'b00000, i_radius, 1'b0});
                n_active = 1'b1;
                o_push   = 1'b1;
            end else if (r_active) begin
                n_off_x  = step_x;
                n_off_y  = step_y;
                n_dec    = $signed(step_dec);
                n_active = !step_done;
                done     = step_done;
                o_push   = 1'b1;
            end
        end
    end

    // The record carries the state as it stands after this item.
    always_comb begin
        o_rec.origin_x = n_org_x;
        o_rec.origin_y = n_org_y;
        o_rec.offset_x = n_off_x;
        o_rec.offset_y = n_off_y;
        o_rec.done     = done;
    end

    // Generator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x  <= '0;
            r_off_y  <= '0;
            r_dec    <= '0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_active <= 1'b0;
        end else begin
            r_off_x  <= n_off_x;
            r_off_y  <= n_off_y;
            r_dec    <= n_dec;
            r_org_x  <= n_org_x;
            r_org_y  <= n_org_y;
            r_active <= n_active;
        end
    end

endmodule

/* hw/rtl/cpg_queue.sv */
// Short FIFO of step records between the front end and the point emitter.
// Depends on cpg_pkg.
module cpg_queue import cpg_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_step_rec i_rec,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_step_rec o_rec
);

    localparam int unsigned PtrW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned CntW = $clog2(Q_DEPTH + 1);

    t_step_rec           r_mem [Q_DEPTH];
    logic [PtrW-1:0]     r_wptr, n_wptr;
    logic [PtrW-1:0]     r_rptr, n_rptr;
    logic [CntW-1:0]     r_count, n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == CntW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill count update with wrap at the depth.
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PtrW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PtrW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Storage for the records.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/cpg_back.sv */
// Point emitter: holds one step record and presents its eight mirrored
// points, one per accepted item on the output channel. Depends on cpg_pkg.
module cpg_back import cpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_step_rec          i_q_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [11:0] o_pixel_x,
    output logic signed [11:0] o_pixel_y,
    output logic        [2:0]  o_octant,
    output logic               o_last_of_step,
    output logic               o_circle_done
);

    t_step_rec   r_rec;
    logic [2:0]  r_cnt;
    logic        r_busy;

    logic        last;
    logic        out_acc;
    logic [11:0] dx;
    logic [11:0] dy;
    logic [11:0] base_x;
    logic [11:0] base_y;

    assign last    = (r_cnt == OCT_LAST);
    assign out_acc = r_busy && i_ready;
    // A new record is loaded when idle or as the eighth point leaves.
    assign o_pop   = i_q_valid && (!r_busy || (out_acc && last));

    // Mirror selection: bit 2 swaps the axes, bit 0 negates x, bit 1 negates y.
    always_comb begin
        dx     = r_cnt[2] ? r_rec.offset_y : r_rec.offset_x;
        dy     = r_cnt[2] ? r_rec.offset_x : r_rec.offset_y;
        base_x = {r_rec.origin_x[10], r_rec.origin_x};
        base_y = {r_rec.origin_y[10], r_rec.origin_y};
        o_pixel_x = $signed(r_cnt[0] ? (base_x - dx) : (base_x + dx));
        o_pixel_y = $signed(r_cnt[1] ? (base_y - dy) : (base_y + dy));
    end

    assign o_valid        = r_busy;
    assign o_octant       = r_cnt;
    assign o_last_of_step = last;
    assign o_circle_done  = r_rec.done;

    // Record holding register; loaded from the queue head.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_q_rec;
        end
    end

    // Point counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (out_acc) begin
                r_cnt <= r_cnt + 3'd1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

/* hw/rtl/circle_point_generator_top.sv */
// With the emitter idle, the first point of a start or active step item is presented once the item
// has passed through the step queue and the emitter's record holding register.
// Throughput: one point per cycle while the output is ready, limited by the single point emitter.
// A step item that arrives while the generator is idle is accepted and yields nothing.
// The front end takes items while the two-entry step queue has room.
// Reset (synchronous, active low) clears the generator state to idle and empties the queue.
module circle_point_generator_top import cpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req_type,
    input  logic signed [10:0] i_center_x,
    input  logic signed [10:0] i_center_y,
    input  logic        [9:0]  i_radius,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [11:0] o_pixel_x,
    output logic signed [11:0] o_pixel_y,
    output logic        [2:0]  o_octant,
    output logic               o_last_of_step,
    output logic               o_circle_done
);

    logic      q_full;
    logic      q_push;
    logic      q_pop;
    logic      q_valid;
    t_step_rec push_rec;
    t_step_rec head_rec;

    // Request handling and decision update.
    cpg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_rec      (push_rec)
    );

    // Step records waiting for the emitter.
    cpg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (head_rec)
    );

    // Eight-way point output.
    cpg_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_rec        (head_rec),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_octant       (o_octant),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

/* hw/rtl/cpg_checker.sv */
// Port-level checks for the circle point generator, bound to the top level.
// Depends only on the top-level ports.
module cpg_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic               i_req_type,
    input  logic signed [10:0] i_center_x,
    input  logic signed [10:0] i_center_y,
    input  logic        [9:0]  i_radius,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [11:0] o_pixel_x,
    input  logic signed [11:0] o_pixel_y,
    input  logic        [2:0]  o_octant,
    input  logic               o_last_of_step,
    input  logic               o_circle_done
);

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
            && $stable(o_octant) && $stable(o_circle_done))
        else $error("output item changed while stalled");

    // Within a step the next point follows at once with the next octant.
    a_octant_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=>
            o_valid && (o_octant == $past(o_octant) + 3'd1))
        else $error("step points not contiguous");

    // The done flag is the same on all points of one step.
    a_done_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=> o_circle_done == $past(o_circle_done))
        else $error("done flag changed within a step");

    // The last-of-step flag marks the eighth point only.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_of_step == (o_octant == 3'd7)))
        else $error("last flag does not match octant");

endmodule

bind circle_point_generator_top cpg_checker u_cpg_checker (.*);
